### src/ghn_pkg.sv
// ----------------------------------------------------------------------------
// ghn_pkg
// Shared constants and direction codes for the geohash neighbor generator.
// ----------------------------------------------------------------------------
package ghn_pkg;

	localparam int SYMBOL_BITS     = 5;
	localparam int MAX_SYMBOLS_DEF = 12;
	localparam int PREC_W          = 4;
	localparam int DIR_W           = 4;

	// direction = row*3 + column, row 0 south, column 0 west
	localparam logic [DIR_W-1:0] DIR_SW   = 4'd0;
	localparam logic [DIR_W-1:0] DIR_S    = 4'd1;
	localparam logic [DIR_W-1:0] DIR_SE   = 4'd2;
	localparam logic [DIR_W-1:0] DIR_W_   = 4'd3;
	localparam logic [DIR_W-1:0] DIR_SELF = 4'd4;
	localparam logic [DIR_W-1:0] DIR_E    = 4'd5;
	localparam logic [DIR_W-1:0] DIR_NW   = 4'd6;
	localparam logic [DIR_W-1:0] DIR_N    = 4'd7;
	localparam logic [DIR_W-1:0] DIR_NE   = 4'd8;

endpackage

### src/geohash_neighbor_generator.sv
// ----------------------------------------------------------------------------
// geohash_neighbor_generator
// Each accepted item is loaded into the work registers, and its results are
// registered on the output register: 8 per item (9 with include_self), one
// per cycle while result_stall is low; the next item loads as the last leaves.
// Reset clears the work and output valid flags and sets include_self to 0.
// ----------------------------------------------------------------------------
module geohash_neighbor_generator import ghn_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int CODE_W      = SYMBOL_BITS * MAX_SYMBOLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_wdata,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [CODE_W-1:0] geohash_code,
	input  logic [PREC_W-1:0] precision,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [DIR_W-1:0]  direction,
	output logic              present,
	output logic [CODE_W-1:0] neighbor_code,
	output logic              last
);

	localparam int LON_W = (CODE_W + 1) / 2;
	localparam int LAT_W = CODE_W / 2;
	localparam int TOT_W = $clog2(CODE_W + 1);

	logic              include_self_q;

	// unpacked item
	logic [LON_W-1:0]  lon_c, lon_s1;
	logic [LAT_W-1:0]  lat_c, lat_s1;
	logic [LON_W-1:0]  lon_unit_c, lon_unit_s1;
	logic [LAT_W-1:0]  lat_unit_c, lat_unit_s1;
	logic [TOT_W-1:0]  shamt_c, shamt_s1;
	logic              nonzero_c, nonzero_s1;
	logic              valid_s1;
	logic [DIR_W-1:0]  dir_s1;

	// cell result
	logic              present_c;
	logic [CODE_W-1:0] code_c;

	logic              out_free;
	logic              emit;
	logic              emit_last;
	logic              take;
	logic [DIR_W-1:0]  dir_next;

	ghn_unpack #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.CODE_W      (CODE_W),
		.LON_W       (LON_W),
		.LAT_W       (LAT_W),
		.TOT_W       (TOT_W)
	) u_unpack (
		.geohash_code (geohash_code),
		.precision    (precision),
		.lon_al       (lon_c),
		.lat_al       (lat_c),
		.lon_unit     (lon_unit_c),
		.lat_unit     (lat_unit_c),
		.shamt        (shamt_c),
		.nonzero      (nonzero_c)
	);

	ghn_cell #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.CODE_W      (CODE_W),
		.LON_W       (LON_W),
		.LAT_W       (LAT_W),
		.TOT_W       (TOT_W)
	) u_cell (
		.direction     (dir_s1),
		.lon_al        (lon_s1),
		.lat_al        (lat_s1),
		.lon_unit      (lon_unit_s1),
		.lat_unit      (lat_unit_s1),
		.shamt         (shamt_s1),
		.nonzero       (nonzero_s1),
		.present       (present_c),
		.neighbor_code (code_c)
	);

	assign out_free   = !result_valid || !result_stall;
	assign emit       = valid_s1 && out_free;
	assign emit_last  = emit && (dir_s1 == DIR_NE);
	assign item_stall = valid_s1 && !emit_last;
	assign take       = item_valid && !item_stall;

	// emission order: self (optional), SW, S, SE, W, E, NW, N, NE
	always_comb begin
		case (dir_s1)
			DIR_SELF: dir_next = DIR_SW;
			DIR_W_:   dir_next = DIR_E;
			default:  dir_next = dir_s1 + DIR_W'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_self_q <= 1'b0;
		end else if (cfg_wen) begin
			include_self_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dir_s1   <= DIR_SW;
		end else if (take) begin
			valid_s1 <= 1'b1;
			dir_s1   <= include_self_q ? DIR_SELF : DIR_SW;
		end else if (emit_last) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			dir_s1 <= dir_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lon_s1      <= lon_c;
			lat_s1      <= lat_c;
			lon_unit_s1 <= lon_unit_c;
			lat_unit_s1 <= lat_unit_c;
			shamt_s1    <= shamt_c;
			nonzero_s1  <= nonzero_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			direction     <= dir_s1;
			present       <= present_c;
			neighbor_code <= code_c;
			last          <= (dir_s1 == DIR_NE);
		end
	end

endmodule

### src/ghn_unpack.sv
// ----------------------------------------------------------------------------
// ghn_unpack
// Saturates the precision, left-aligns the code and splits it into
// MSB-aligned longitude and latitude words with their unit steps.
// ----------------------------------------------------------------------------
module ghn_unpack import ghn_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int CODE_W      = SYMBOL_BITS * MAX_SYMBOLS,
	parameter int LON_W       = (CODE_W + 1) / 2,
	parameter int LAT_W       = CODE_W / 2,
	parameter int TOT_W       = $clog2(CODE_W + 1)
) (
	input  logic [CODE_W-1:0] geohash_code,
	input  logic [PREC_W-1:0] precision,
	output logic [LON_W-1:0]  lon_al,
	output logic [LAT_W-1:0]  lat_al,
	output logic [LON_W-1:0]  lon_unit,
	output logic [LAT_W-1:0]  lat_unit,
	output logic [TOT_W-1:0]  shamt,
	output logic              nonzero
);

	logic [PREC_W-1:0] prec_sat;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-1:0]  lon_bits;
	logic [TOT_W-1:0]  lat_bits;
	logic [CODE_W-1:0] aligned;

	always_comb begin
		if (precision > PREC_W'(MAX_SYMBOLS)) begin
			prec_sat = PREC_W'(MAX_SYMBOLS);
		end else begin
			prec_sat = precision;
		end
		total    = TOT_W'(prec_sat) * TOT_W'(SYMBOL_BITS);
		lon_bits = (total + TOT_W'(1)) >> 1;
		lat_bits = total >> 1;
		shamt    = TOT_W'(CODE_W) - total;
		nonzero  = (prec_sat != '0);
		// unused high bits fall off the top here
		aligned  = geohash_code << shamt;
		for (int j = 0; j < LON_W; j++) begin
			lon_al[LON_W-1-j] = aligned[CODE_W-1-2*j];
		end
		for (int j = 0; j < LAT_W; j++) begin
			lat_al[LAT_W-1-j] = aligned[CODE_W-2-2*j];
		end
		lon_unit = LON_W'(1) << (TOT_W'(LON_W) - lon_bits);
		lat_unit = LAT_W'(1) << (TOT_W'(LAT_W) - lat_bits);
	end

endmodule

### src/ghn_cell.sv
// ----------------------------------------------------------------------------
// ghn_cell
// Steps the aligned coordinates one cell in the given direction, checks the
// poles and re-interleaves the result into a packed code.
// ----------------------------------------------------------------------------
module ghn_cell import ghn_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int CODE_W      = SYMBOL_BITS * MAX_SYMBOLS,
	parameter int LON_W       = (CODE_W + 1) / 2,
	parameter int LAT_W       = CODE_W / 2,
	parameter int TOT_W       = $clog2(CODE_W + 1)
) (
	input  logic [DIR_W-1:0]  direction,
	input  logic [LON_W-1:0]  lon_al,
	input  logic [LAT_W-1:0]  lat_al,
	input  logic [LON_W-1:0]  lon_unit,
	input  logic [LAT_W-1:0]  lat_unit,
	input  logic [TOT_W-1:0]  shamt,
	input  logic              nonzero,
	output logic              present,
	output logic [CODE_W-1:0] neighbor_code
);

	logic              west, east, south, north;
	logic [LON_W-1:0]  nlon;
	logic [LAT_W-1:0]  nlat;
	logic [CODE_W-1:0] aligned;

	always_comb begin
		west  = (direction == DIR_SW) || (direction == DIR_W_) || (direction == DIR_NW);
		east  = (direction == DIR_SE) || (direction == DIR_E)  || (direction == DIR_NE);
		south = (direction == DIR_SW) || (direction == DIR_S)  || (direction == DIR_SE);
		north = (direction == DIR_NW) || (direction == DIR_N)  || (direction == DIR_NE);

		// longitude wraps through the dropped carry of the aligned word
		if (west) begin
			nlon = lon_al - lon_unit;
		end else if (east) begin
			nlon = lon_al + lon_unit;
		end else begin
			nlon = lon_al;
		end
		if (south) begin
			nlat = lat_al - lat_unit;
		end else if (north) begin
			nlat = lat_al + lat_unit;
		end else begin
			nlat = lat_al;
		end

		present = nonzero
			&& !(south && (lat_al == '0))
			&& !(north && ((lat_al | (lat_unit - LAT_W'(1))) == '1));

		aligned = '0;
		for (int j = 0; j < LON_W; j++) begin
			aligned[CODE_W-1-2*j] = nlon[LON_W-1-j];
		end
		for (int j = 0; j < LAT_W; j++) begin
			aligned[CODE_W-2-2*j] = nlat[LAT_W-1-j];
		end

		if (present) begin
			neighbor_code = aligned >> shamt;
		end else begin
			neighbor_code = '0;
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for geohash_neighbor_generator. Geohash items are driven with
// random gaps and the result side stalls at random, except in a steady-flow
// phase. Each accepted item is predicted into up to nine neighbor cells,
// and each result is checked field by field against the oldest predicted cell.
// ----------------------------------------------------------------------------
module testbench;
	import ghn_pkg::*;

	localparam int CODE_W = SYMBOL_BITS * MAX_SYMBOLS_DEF;

	typedef struct packed {
		logic [DIR_W-1:0]  dir;
		logic              present;
		logic [CODE_W-1:0] code;
		logic              last;
	} cell_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic              cfg_wdata = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [CODE_W-1:0] geohash_code = '0;
	logic [PREC_W-1:0] precision = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [DIR_W-1:0]  direction;
	logic              present;
	logic [CODE_W-1:0] neighbor_code;
	logic              last;

	cell_t expected_cells[$];
	cell_t seen_cell;
	cell_t want_cell;
	bit    self_enabled = 1'b0;
	bit    steady_flow = 1'b0;
	int    error_count = 0;

	geohash_neighbor_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.geohash_code (geohash_code),
		.precision    (precision),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.direction    (direction),
		.present      (present),
		.neighbor_code(neighbor_code),
		.last         (last)
	);

	always #2 clk = ~clk;

	initial begin
		#400_000;
		$display("geohash_neighbor_generator regression: fail");
		$finish;
	end

	function automatic void note_error(input string msg);
		if (error_count < 10) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
		error_count++;
	endfunction

	// build a packed code from separate lon/lat values, lon bit first
	function automatic logic [CODE_W-1:0] interleave_lonlat(input logic [63:0] lon,
			input logic [63:0] lat, input int total);
		logic [CODE_W-1:0] res;
		int lonbits;
		int latbits;
		res = '0;
		lonbits = (total + 1) / 2;
		latbits = total / 2;
		for (int i = 0; i < total; i++) begin
			if (i % 2 == 0) begin
				res = {res[CODE_W-2:0], lon[lonbits-1-i/2]};
			end else begin
				res = {res[CODE_W-2:0], lat[latbits-1-i/2]};
			end
		end
		return res;
	endfunction

	function automatic void predict_neighbors(input logic [CODE_W-1:0] code_in,
			input logic [PREC_W-1:0] prec_in);
		logic [63:0] code;
		logic [63:0] lon;
		logic [63:0] lat;
		logic [63:0] lonmask;
		logic [63:0] latmask;
		logic [63:0] nlon;
		logic [63:0] nlat;
		int          prec;
		int          total;
		int          lonbits;
		int          latbits;
		int          row;
		int          col;
		int          nres;
		int          count;
		bit          ok;
		cell_t       c;
		prec = (prec_in > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(prec_in);
		total = prec * SYMBOL_BITS;
		code = 64'(code_in) & ((64'd1 << total) - 64'd1);
		lonbits = (total + 1) / 2;
		latbits = total / 2;
		lonmask = (64'd1 << lonbits) - 64'd1;
		latmask = (64'd1 << latbits) - 64'd1;
		lon = '0;
		lat = '0;
		for (int i = 0; i < total; i++) begin
			if (i % 2 == 0) begin
				lon = {lon[62:0], code[total-1-i]};
			end else begin
				lat = {lat[62:0], code[total-1-i]};
			end
		end
		nres = self_enabled ? 9 : 8;
		count = 0;
		if (self_enabled) begin
			c.dir = DIR_SELF;
			c.present = (prec != 0);
			c.code = (prec != 0) ? code[CODE_W-1:0] : '0;
			c.last = (count + 1 == nres);
			expected_cells.push_back(c);
			count++;
		end
		for (int d = 0; d < 9; d++) begin
			if (d == DIR_SELF) begin
				continue;
			end
			row = d / 3;
			col = d % 3;
			ok = (prec != 0);
			// no cell past either pole
			if (row == 0 && lat == 0) begin
				ok = 1'b0;
			end
			if (row == 2 && lat == latmask) begin
				ok = 1'b0;
			end
			c.dir = DIR_W'(d);
			c.present = ok;
			c.code = '0;
			if (ok) begin
				nlon = (lon + 64'(col) + lonmask) & lonmask;
				nlat = (lat + 64'(row) - 64'd1) & latmask;
				c.code = interleave_lonlat(nlon, nlat, total);
			end
			c.last = (count + 1 == nres);
			expected_cells.push_back(c);
			count++;
		end
	endfunction

	// result side stall pattern
	always @(negedge clk) begin
		result_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen_cell = '{direction, present, neighbor_code, last};
			if (expected_cells.size() == 0) begin
				note_error($sformatf("unexpected result dir=%0d present=%0b code=%h last=%0b",
					direction, present, neighbor_code, last));
			end else begin
				want_cell = expected_cells.pop_front();
				if (seen_cell !== want_cell) begin
					note_error($sformatf({"result mismatch: exp dir=%0d present=%0b code=%h ",
						"last=%0b, got dir=%0d present=%0b code=%h last=%0b"},
						want_cell.dir, want_cell.present, want_cell.code, want_cell.last,
						direction, present, neighbor_code, last));
				end
			end
		end
	end

	// called right after a rising edge; leaves valid high after the transfer
	task automatic send_geohash(input logic [CODE_W-1:0] code, input logic [PREC_W-1:0] prec);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < 29) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		geohash_code <= code;
		precision <= prec;
		do begin
			@(posedge clk);
		end while (!(item_valid && !item_stall));
		predict_neighbors(code, prec);
	endtask

	task automatic stop_items();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (expected_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_include_self(input bit value);
		stop_items();
		wait_results_drained();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		self_enabled = value;
	endtask

	task automatic send_random_geohash();
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] mask;
		logic [PREC_W-1:0] prec;
		logic [63:0]       lon;
		int                r;
		int                total;
		r = $urandom_range(99);
		if (r < 5) begin
			prec = '0;
		end else if (r < 10) begin
			prec = PREC_W'($urandom_range(15, MAX_SYMBOLS_DEF + 1));
		end else begin
			prec = PREC_W'($urandom_range(MAX_SYMBOLS_DEF, 1));
		end
		code = CODE_W'({$urandom, $urandom});
		total = ((prec > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(prec)) * SYMBOL_BITS;
		mask = CODE_W'((64'd1 << total) - 64'd1);
		// steer some items onto the polar rows
		if (total != 0 && $urandom_range(99) < 25) begin
			lon = {$urandom, $urandom};
			code = (code & ~mask) | interleave_lonlat(lon,
				$urandom_range(1) ? 64'd0 : '1, total);
		end
		// most codes keep the unused high bits at zero
		if ($urandom_range(99) < 60) begin
			code = code & mask;
		end
		send_geohash(code, prec);
	endtask

	task automatic test_directed();
		set_include_self(1'b1);
		send_geohash('0, 4'd0);
		send_geohash('1, 4'd0);
		send_geohash(60'd0, 4'd1);
		send_geohash(60'd31, 4'd1);
		send_geohash(60'd10, 4'd1);
		send_geohash('0, 4'd12);
		send_geohash('1, 4'd12);
		send_geohash(60'h555_5555_5555_5555, 4'd12);
		send_geohash(60'hAAA_AAAA_AAAA_AAAA, 4'd12);
		send_geohash('1, 4'd13);
		send_geohash(60'h123_4567_89AB_CDEF, 4'd15);
		send_geohash('1, 4'd5);
		send_geohash(60'h3FF, 4'd2);
		send_geohash(60'h7FFF, 4'd3);
		send_geohash(60'h1234_5678, 4'd7);
		set_include_self(1'b0);
		send_geohash('0, 4'd0);
		send_geohash(60'd0, 4'd1);
		send_geohash(60'd31, 4'd1);
		send_geohash('1, 4'd12);
		send_geohash('0, 4'd12);
		send_geohash(60'h0F0F_0F0F, 4'd11);
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			set_include_self(phase % 2 == 0);
			for (int n = 0; n < 70; n++) begin
				send_random_geohash();
				// let the result side catch up completely once
				if (phase == 1 && n == 35) begin
					stop_items();
					wait_results_drained();
				end
			end
		end
	endtask

	task automatic test_steady_flow();
		set_include_self(1'b1);
		steady_flow = 1'b1;
		for (int n = 0; n < 40; n++) begin
			send_random_geohash();
		end
		stop_items();
		wait_results_drained();
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_steady_flow();
		stop_items();
		wait_results_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_cells.size() == 0) begin
			$display("geohash_neighbor_generator regression: pass");
		end else begin
			$display("geohash_neighbor_generator regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
src/ghn_pkg.sv
src/ghn_unpack.sv
src/ghn_cell.sv
src/geohash_neighbor_generator.sv
tb/testbench.sv
